FILE: rtl/core/h2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // hue resolution: one degree is 2**HUE_FRAC_BITS hue units
  localparam int HUE_FRAC_BITS = 4;

  localparam int HUE_W    = 13;
  localparam int PCT_W    = 7;
  localparam int COMP_W   = 8;
  localparam int SV_W     = 2 * PCT_W;
  localparam int PCT_MAX  = 100;
  localparam int COMP_MAX = 255;

  localparam longint unsigned SECTOR_UNITS = 64'd60 << HUE_FRAC_BITS;
  localparam longint unsigned HUE_LIMIT    = 64'd360 << HUE_FRAC_BITS;
  localparam int NUM_SECTORS = 6;

  localparam int UNIT_W  = $clog2(SECTOR_UNITS + 1);
  localparam int BASE_W  = $clog2((NUM_SECTORS - 1) * SECTOR_UNITS + 1);
  localparam int HCALC_W = (HUE_W > BASE_W) ? HUE_W : BASE_W;

  // full-scale numerator; each component is floor(num * 255 / DEN)
  localparam longint unsigned DEN = 64'(PCT_MAX * PCT_MAX) * SECTOR_UNITS;
  localparam int NUM_W  = $clog2(DEN + 1);
  localparam int PROD_W = NUM_W + COMP_W;

  // reciprocal of DEN, never above the exact value
  localparam longint unsigned RECIP = (64'd1 << PROD_W) / DEN;
  localparam int RECIP_W = $clog2(RECIP + 1);

  // pipeline depth
  localparam int FRONT_STAGES = 3;
  localparam int SCALE_STAGES = 4;
  localparam int NUM_STAGES   = FRONT_STAGES + SCALE_STAGES;

  localparam int SEC_W = 3;

  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [SEC_W-1:0]  sec_t;

  // 60-degree sectors
  localparam sec_t SEC_RED_YELLOW    = 3'd0;
  localparam sec_t SEC_YELLOW_GREEN  = 3'd1;
  localparam sec_t SEC_GREEN_CYAN    = 3'd2;
  localparam sec_t SEC_CYAN_BLUE     = 3'd3;
  localparam sec_t SEC_BLUE_MAGENTA  = 3'd4;
  localparam sec_t SEC_MAGENTA_RED   = 3'd5;

  // first hue of a sector
  function automatic logic [BASE_W-1:0] sector_base(input sec_t sec);
    return BASE_W'(64'(sec) * SECTOR_UNITS);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/h2r_front.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_front import h2r_pkg::*; (
  input  wire logic                     clk,
  input  wire logic [FRONT_STAGES-1:0]  en,
  input  wire logic [HUE_W-1:0]         hue,
  input  wire logic [PCT_W-1:0]         saturation,
  input  wire logic [PCT_W-1:0]         brightness,
  output num_t                          red_num,
  output num_t                          green_num,
  output num_t                          blue_num,
  output logic                          range_error
);

  // stage 1 comb
  sec_t               sec_c;
  logic [HCALC_W-1:0] pos_c;
  logic [UNIT_W-1:0]  w_c;
  logic               err_c;

  // stage 1 regs
  logic              err1;
  sec_t              sec1;
  logic [SV_W-1:0]   sv1;
  logic [SV_W-1:0]   v100_1;
  logic [UNIT_W-1:0] w1;

  // stage 2 regs
  logic err2;
  sec_t sec2;
  num_t a2;
  num_t b2;
  num_t c2;

  num_t mid_c;

  always_comb begin
    sec_c = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (64'(hue) >= 64'(k) * SECTOR_UNITS) begin
        sec_c = sec_c + SEC_W'(1);
      end
    end
    pos_c = HCALC_W'(hue) - HCALC_W'(sector_base(sec_c));
    // rising edge in even sectors, falling edge in odd ones
    if (sec_c[0]) begin
      w_c = UNIT_W'(HCALC_W'(SECTOR_UNITS) - pos_c);
    end else begin
      w_c = UNIT_W'(pos_c);
    end
    err_c = (64'(hue) > HUE_LIMIT) || (saturation > PCT_W'(PCT_MAX))
            || (brightness > PCT_W'(PCT_MAX));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      err1   <= err_c;
      sec1   <= sec_c;
      sv1    <= SV_W'(saturation) * SV_W'(brightness);
      v100_1 <= SV_W'(brightness) * SV_W'(PCT_MAX);
      w1     <= w_c;
    end
  end

  // chroma share, offset share and full value
  always_ff @(posedge clk) begin
    if (en[1]) begin
      err2 <= err1;
      sec2 <= sec1;
      a2   <= NUM_W'(sv1) * NUM_W'(w1);
      b2   <= NUM_W'(v100_1 - sv1) * NUM_W'(SECTOR_UNITS);
      c2   <= NUM_W'(v100_1) * NUM_W'(SECTOR_UNITS);
    end
  end

  assign mid_c = a2 + b2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      range_error <= err2;
      if (err2) begin
        red_num   <= '0;
        green_num <= '0;
        blue_num  <= '0;
      end else begin
        unique case (sec2)
          SEC_RED_YELLOW: begin
            red_num <= c2;    green_num <= mid_c; blue_num <= b2;
          end
          SEC_YELLOW_GREEN: begin
            red_num <= mid_c; green_num <= c2;    blue_num <= b2;
          end
          SEC_GREEN_CYAN: begin
            red_num <= b2;    green_num <= c2;    blue_num <= mid_c;
          end
          SEC_CYAN_BLUE: begin
            red_num <= b2;    green_num <= mid_c; blue_num <= c2;
          end
          SEC_BLUE_MAGENTA: begin
            red_num <= mid_c; green_num <= b2;    blue_num <= c2;
          end
          default: begin
            red_num <= c2;    green_num <= b2;    blue_num <= mid_c;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/h2r_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_scale import h2r_pkg::*; (
  input  wire logic                     clk,
  input  wire logic [SCALE_STAGES-1:0]  en,
  input  wire num_t                     num,
  output comp_t                         comp
);

  localparam int MUL_W = PROD_W + RECIP_W;

  logic [PROD_W-1:0] p4;
  logic [PROD_W-1:0] p5;
  logic [PROD_W-1:0] p6;
  comp_t             q5;
  comp_t             q6;
  logic [PROD_W-1:0] qd6;
  logic [MUL_W-1:0]  est_c;
  logic [PROD_W-1:0] rem_c;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p4 <= PROD_W'(num) * PROD_W'(COMP_MAX);
    end
  end

  // quotient estimate, low by at most one
  assign est_c = MUL_W'(p4) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p5 <= p4;
      q5 <= est_c[PROD_W +: COMP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p6  <= p5;
      q6  <= q5;
      qd6 <= PROD_W'(q5) * PROD_W'(DEN);
    end
  end

  assign rem_c = p6 - qd6;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      comp <= (rem_c >= PROD_W'(DEN)) ? q6 + COMP_W'(1) : q6;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hsv_to_rgb_converter.sv
// hsv to rgb pixel converter, seven register stages from request to result
// throughput: one pixel per cycle while rgb_ready is not stalling the output, set by the fully pipelined datapath
// a stall passes back combinationally through the enable chain, so empty stages still fill under a stall
// reset (rst, synchronous) clears the valid bits; the datapath has no reset
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter import h2r_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // hsv request channel
  input  wire logic              hsv_valid,
  output logic                   hsv_ready,
  input  wire logic [HUE_W-1:0]  hue,
  input  wire logic [PCT_W-1:0]  saturation,
  input  wire logic [PCT_W-1:0]  brightness,
  // rgb result channel
  output logic                   rgb_valid,
  input  wire logic              rgb_ready,
  output comp_t                  red,
  output comp_t                  green,
  output comp_t                  blue,
  output logic                   range_error
);

  // one valid bit per stage, stage 0 first
  logic [NUM_STAGES-1:0]   vld;
  logic [NUM_STAGES-1:0]   vld_in;
  // stage load enable: stage is empty or its content moves on
  logic [NUM_STAGES-1:0]   en;

  num_t red_num;
  num_t green_num;
  num_t blue_num;
  logic front_err;

  // error flag riding alongside the scaling stages
  logic [SCALE_STAGES-1:0] err_pipe;
  logic [SCALE_STAGES-1:0] err_in;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || rgb_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign hsv_ready = en[0];
  assign vld_in    = {vld[NUM_STAGES-2:0], hsv_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // range check, chroma products and sector placement
  h2r_front u_front (
    .clk         (clk),
    .en          (en[FRONT_STAGES-1:0]),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .red_num     (red_num),
    .green_num   (green_num),
    .blue_num    (blue_num),
    .range_error (front_err)
  );

  // scale each component to 0..255 with truncation
  h2r_scale u_scale_red (
    .clk  (clk),
    .en   (en[NUM_STAGES-1:FRONT_STAGES]),
    .num  (red_num),
    .comp (red)
  );

  h2r_scale u_scale_green (
    .clk  (clk),
    .en   (en[NUM_STAGES-1:FRONT_STAGES]),
    .num  (green_num),
    .comp (green)
  );

  h2r_scale u_scale_blue (
    .clk  (clk),
    .en   (en[NUM_STAGES-1:FRONT_STAGES]),
    .num  (blue_num),
    .comp (blue)
  );

  assign err_in = {err_pipe[SCALE_STAGES-2:0], front_err};

  always_ff @(posedge clk) begin
    for (int k = 0; k < SCALE_STAGES; k++) begin
      if (en[FRONT_STAGES+k]) begin
        err_pipe[k] <= err_in[k];
      end
    end
  end

  assign rgb_valid   = vld[NUM_STAGES-1];
  assign range_error = err_pipe[SCALE_STAGES-1];

  // an out-of-range pixel comes out black
  a_err_black: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && range_error |-> red == '0 && green == '0 && blue == '0)
    else $error("range error with nonzero components");

  // with no result waiting, the pipeline must take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rgb_valid |-> hsv_ready)
    else $error("request refused while output is empty");

  // requests in flight change only by what enters and what leaves
  a_conservation: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(vld) == $past($countones(vld))
      + $past(32'(hsv_valid && hsv_ready)) - $past(32'(rgb_valid && rgb_ready)))
    else $error("request lost or duplicated in pipeline");

endmodule

`default_nettype wire
